### rtl/core/quaternion_yaw_encoder_macros.svh
// Assertion macros for the quaternion yaw encoder.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef QUATERNION_YAW_ENCODER_MACROS_SVH
`define QUATERNION_YAW_ENCODER_MACROS_SVH
`ifndef SYNTHESIS
`define QYE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("quaternion yaw encoder assertion failed");
`define QYE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("quaternion yaw encoder assertion failed");
`define QYE_ASSERT_LAT(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("quaternion yaw encoder assertion failed");
`else
`define QYE_ASSERT_IMP(lbl, ante, cons)
`define QYE_ASSERT_NEXT(lbl, ante, cons)
`define QYE_ASSERT_LAT(lbl, ante, dly, cons)
`endif
`endif

### rtl/core/qye_pkg.sv
// Shared types, constants and the arctangent table of the quaternion yaw encoder.
// No dependencies.
`timescale 1ns / 1ps
package qye_pkg;

  // Vector and angle widths inside the datapath.
  localparam int SUM_W = 34;   // numerator and denominator, Q.28
  localparam int VEC_W = 36;   // CORDIC x and y, with room for the gain
  localparam int ANG_W = 34;   // angle accumulator, Q2.30

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam int FRONT_LAT = 3;
  localparam int QUEUE_LAT = 1;
  localparam int MAP_LAT   = 7;
  localparam int MAX_STEPS = 24;

  localparam logic signed [SUM_W-1:0] DEN_ONE     = 34'sd268435456;
  localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] ROUND_Q30   = 34'sd65536;

  localparam logic signed [16:0] ANGLE_LIMIT_W   = 17'sd25736;
  localparam logic signed [15:0] ANGLE_LIMIT     = 16'sd25736;
  localparam logic signed [15:0] NEG_ANGLE_LIMIT = -16'sd25736;

  // Code mapping: code = floor((3125u - 296) * 65535 / 512 / 314159),
  // with u the angle offset by the limit.
  localparam logic [15:0] ANGLE_OFFSET = 16'd25736;
  localparam logic [11:0] MAP_MUL      = 12'd3125;
  localparam logic [27:0] MAP_SUB      = 28'd296;
  localparam logic [18:0] MAP_DIV      = 19'd314159;
  localparam logic [16:0] MAP_RECIP    = 17'd109370;  // floor(2^35 / 314159)
  localparam logic [15:0] CODE_MAX     = 16'hFFFF;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } quat_in_t;

  typedef struct packed {
    logic signed [15:0] yaw_angle;
    logic        [15:0] yaw_code;
  } yaw_out_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
    logic              full;
  } queue_stat_t;

  typedef struct packed {
    logic [1:0] inflight;
  } front_stat_t;

  // atan(2^-i) in Q2.30, rounded to nearest.
  function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ANG_W-1:0] res;
    case (idx)
      5'd0:  res = 34'sd843314857;
      5'd1:  res = 34'sd497837829;
      5'd2:  res = 34'sd263043837;
      5'd3:  res = 34'sd133525159;
      5'd4:  res = 34'sd67021687;
      5'd5:  res = 34'sd33543516;
      5'd6:  res = 34'sd16775851;
      5'd7:  res = 34'sd8388437;
      5'd8:  res = 34'sd4194283;
      5'd9:  res = 34'sd2097149;
      5'd10: res = 34'sd1048576;
      5'd11: res = 34'sd524288;
      5'd12: res = 34'sd262144;
      5'd13: res = 34'sd131072;
      5'd14: res = 34'sd65536;
      5'd15: res = 34'sd32768;
      5'd16: res = 34'sd16384;
      5'd17: res = 34'sd8192;
      5'd18: res = 34'sd4096;
      5'd19: res = 34'sd2048;
      5'd20: res = 34'sd1024;
      5'd21: res = 34'sd512;
      5'd22: res = 34'sd256;
      5'd23: res = 34'sd128;
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

### rtl/core/qye_front.sv
// Front end: forms the yaw numerator and denominator and sets up the CORDIC start vector.
// Depends on qye_pkg.
`timescale 1ns / 1ps
module qye_front import qye_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  quat_in_t    in_data,
  output logic        out_valid,
  output vec_t        out_vec,
  output front_stat_t stat
);

  logic v1_r, v2_r, v3_r;
  logic signed [31:0] p_wz_r, p_xy_r, p_yy_r, p_zz_r;
  logic signed [31:0] p_wz_nxt, p_xy_nxt, p_yy_nxt, p_zz_nxt;
  logic signed [32:0] sum_n, sum_d;
  logic signed [SUM_W-1:0] num_r, den_r, num_nxt, den_nxt;
  logic signed [VEC_W-1:0] xe, ye;
  logic num_zero, num_pos, den_neg;
  vec_t vec_r, vec_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Stage one: the four products.
  assign p_wz_nxt = 32'(in_data.quat_w * in_data.quat_z);
  assign p_xy_nxt = 32'(in_data.quat_x * in_data.quat_y);
  assign p_yy_nxt = 32'(in_data.quat_y * in_data.quat_y);
  assign p_zz_nxt = 32'(in_data.quat_z * in_data.quat_z);

  // Stage two: numerator 2(wz + xy) and denominator 1 - 2(y^2 + z^2), both Q.28.
  assign sum_n   = 33'(p_wz_r) + 33'(p_xy_r);
  assign sum_d   = 33'(p_yy_r) + 33'(p_zz_r);
  assign num_nxt = {sum_n, 1'b0};
  assign den_nxt = DEN_ONE - {sum_d, 1'b0};

  // Stage three: classify the item. A zero numerator leaves y at zero so that
  // every CORDIC step holds, and the angle comes straight from the start value.
  // A negative denominator is turned a quarter turn into the right half plane.
  assign xe       = VEC_W'(den_r);
  assign ye       = VEC_W'(num_r);
  assign num_zero = (num_r == '0);
  assign num_pos  = !num_r[SUM_W-1] && !num_zero;
  assign den_neg  = den_r[SUM_W-1];

  always_comb begin
    vec_nxt.x = xe;
    vec_nxt.y = ye;
    vec_nxt.z = '0;
    if (num_zero) begin
      vec_nxt.y = '0;
      vec_nxt.z = den_neg ? PI_Q30 : '0;
    end else if (den_neg) begin
      if (num_pos) begin
        vec_nxt.x = ye;
        vec_nxt.y = -xe;
        vec_nxt.z = HALF_PI_Q30;
      end else begin
        vec_nxt.x = -ye;
        vec_nxt.y = xe;
        vec_nxt.z = -HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_wz_r <= p_wz_nxt;
    p_xy_r <= p_xy_nxt;
    p_yy_r <= p_yy_nxt;
    p_zz_r <= p_zz_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    vec_r  <= vec_nxt;
  end

  assign out_valid     = v3_r;
  assign out_vec       = vec_r;
  assign stat.inflight = 2'(v1_r) + 2'(v2_r) + 2'(v3_r);

endmodule

### rtl/core/qye_queue.sv
// Short queue of CORDIC start vectors between the front and back ends.
// Depends on qye_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "quaternion_yaw_encoder_macros.svh"
module qye_queue import qye_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  vec_t        push_vec,
  output logic        pop,
  output vec_t        pop_vec,
  output queue_stat_t stat
);

  vec_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  // The back end never stalls, so the head leaves as soon as it is there.
  assign pop     = (count_r != '0);
  assign pop_vec = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
  assign rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
  assign count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_vec;
    end
  end

  assign stat.count = count_r;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));

  `QYE_ASSERT_IMP(a_no_overflow, push, count_r != QCNT_W'(QUEUE_DEPTH))
  `QYE_ASSERT_IMP(a_ptr_count, 1'b1, QPTR_W'(wr_ptr_r - rd_ptr_r) == count_r[QPTR_W-1:0])
  `QYE_ASSERT_NEXT(a_push_drains, push, pop)

endmodule

### rtl/core/qye_cordic.sv
// Back end, first part: pipelined CORDIC vectoring, one rotation per stage.
// Depends on qye_pkg.
`timescale 1ns / 1ps
module qye_cordic import qye_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  vec_t                    in_vec,
  output logic                    out_valid,
  output logic signed [ANG_W-1:0] out_z
);

  logic                    v_r [STEPS];
  logic signed [VEC_W-1:0] x_r [STEPS];
  logic signed [VEC_W-1:0] y_r [STEPS];
  logic signed [ANG_W-1:0] z_r [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic                    v_in;
    logic signed [VEC_W-1:0] x_in, y_in, xs, ys, x_nxt, y_nxt;
    logic signed [ANG_W-1:0] z_in, z_nxt, atan_i;

    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign x_in = in_vec.x;
      assign y_in = in_vec.y;
      assign z_in = in_vec.z;
    end else begin : g_rest
      assign v_in = v_r[i-1];
      assign x_in = x_r[i-1];
      assign y_in = y_r[i-1];
      assign z_in = z_r[i-1];
    end

    assign xs     = x_in >>> i;
    assign ys     = y_in >>> i;
    assign atan_i = atan_q30(5'(i));

    // Rotate towards the x axis; a vector already on it stays put.
    always_comb begin
      x_nxt = x_in;
      y_nxt = y_in;
      z_nxt = z_in;
      if (y_in[VEC_W-1]) begin
        x_nxt = x_in - ys;
        y_nxt = y_in + xs;
        z_nxt = z_in - atan_i;
      end else if (y_in != '0) begin
        x_nxt = x_in + ys;
        y_nxt = y_in - xs;
        z_nxt = z_in + atan_i;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      x_r[i] <= x_nxt;
      y_r[i] <= y_nxt;
      z_r[i] <= z_nxt;
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign out_z     = z_r[STEPS-1];

endmodule

### rtl/core/qye_map.sv
// Back end, second part: rounds the angle to Q3.13, clamps it and maps it to a 16-bit code.
// Depends on qye_pkg.
`timescale 1ns / 1ps
module qye_map import qye_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic signed [ANG_W-1:0] in_z,
  output logic                    out_valid,
  output yaw_out_t                out_data
);

  logic [MAP_LAT-1:0] v_r;

  // Stage zero: round and clamp.
  logic signed [ANG_W-1:0] zr;
  logic signed [16:0]      a_full;
  logic signed [15:0]      a0_nxt, a0_r, a1_r, a2_r, a3_r, a4_r, a5_r;
  logic        [15:0]      u0_nxt, u0_r;
  // Stage one: scaled offset.
  logic        [31:0]      uv_prod;
  logic        [27:0]      v1_nxt, v1_r;
  logic                    zero1_r, zero2_r, zero3_r, zero4_r, zero5_r;
  // Stage two: times 65535, over 512.
  logic        [43:0]      p_full;
  logic        [34:0]      p2_nxt, p2_r, p3_r, p4_r, p5_r;
  // Stage three: reciprocal estimate of the quotient.
  logic        [51:0]      prod3;
  logic        [16:0]      q3_nxt, q3_r, q4_r;
  // Stage four forms the back product, stage five corrects the estimate.
  logic        [35:0]      m4_nxt, m4_r, rem5;
  logic        [17:0]      q5;
  yaw_out_t                out_nxt, out_r;

  assign zr     = in_z + ROUND_Q30;
  assign a_full = zr[ANG_W-1:17];

  always_comb begin
    if (a_full > ANGLE_LIMIT_W) begin
      a0_nxt = ANGLE_LIMIT;
    end else if (a_full < -ANGLE_LIMIT_W) begin
      a0_nxt = NEG_ANGLE_LIMIT;
    end else begin
      a0_nxt = 16'(a_full);
    end
  end

  assign u0_nxt  = 16'(a0_nxt) + ANGLE_OFFSET;
  assign uv_prod = 32'(u0_r) * 32'(MAP_MUL);
  assign v1_nxt  = 28'(uv_prod) - MAP_SUB;

  assign p_full = {v1_r, 16'h0000} - {16'h0000, v1_r};
  assign p2_nxt = p_full[43:9];

  // The estimate is at most one below the true quotient.
  assign prod3  = 52'(p3_r) * 52'(MAP_RECIP);
  assign q3_nxt = prod3[51:35];

  assign m4_nxt = 36'(q3_r) * 36'(MAP_DIV);

  assign rem5 = 36'(p5_r) - m4_r;
  assign q5   = (rem5 >= 36'(MAP_DIV)) ? 18'(q4_r) + 18'd1 : 18'(q4_r);

  always_comb begin
    out_nxt.yaw_angle = a5_r;
    if (zero5_r) begin
      out_nxt.yaw_code = '0;
    end else if (q5 > 18'(CODE_MAX)) begin
      out_nxt.yaw_code = CODE_MAX;
    end else begin
      out_nxt.yaw_code = q5[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[MAP_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    a0_r    <= a0_nxt;
    u0_r    <= u0_nxt;
    a1_r    <= a0_r;
    v1_r    <= v1_nxt;
    zero1_r <= (u0_r == '0);
    a2_r    <= a1_r;
    p2_r    <= p2_nxt;
    zero2_r <= zero1_r;
    a3_r    <= a2_r;
    p3_r    <= p2_r;
    zero3_r <= zero2_r;
    a4_r    <= a3_r;
    p4_r    <= p3_r;
    q3_r    <= q3_nxt;
    zero4_r <= zero3_r;
    a5_r    <= a4_r;
    p5_r    <= p4_r;
    q4_r    <= q3_r;
    m4_r    <= m4_nxt;
    zero5_r <= zero4_r;
    out_r   <= out_nxt;
  end

  assign out_valid = v_r[MAP_LAT-1];
  assign out_data  = out_r;

endmodule

### rtl/core/quaternion_yaw_encoder.sv
// Throughput: one request per cycle; the CORDIC pipeline has one stage per rotation step.
// busy is high only in reset: the back end never stalls, so the queue and the front-end
// stages together never exceed the queue depth.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (synchronous, active low) empties every stage and the queue, and holds busy high.
`timescale 1ns / 1ps
`include "quaternion_yaw_encoder_macros.svh"
module quaternion_yaw_encoder import qye_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  quat_in_t in_data,
  output logic     out_valid,
  output yaw_out_t out_data
);

  localparam int STEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam int LAT   = FRONT_LAT + QUEUE_LAT + STEPS + MAP_LAT;

  logic                    accept;
  logic                    f_valid, q_pop, c_valid;
  vec_t                    f_vec, q_vec;
  front_stat_t             f_stat;
  queue_stat_t             q_stat;
  logic signed [ANG_W-1:0] c_z;
  logic [QCNT_W:0]         credit;

  // Requests still in the front end will land in the queue, so count them too.
  assign credit = (QCNT_W+1)'(q_stat.count) + (QCNT_W+1)'(f_stat.inflight);
  assign busy   = !rst_n || (credit > (QCNT_W+1)'(QUEUE_DEPTH));
  assign accept = start && !busy;

  qye_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_data   (in_data),
    .out_valid (f_valid),
    .out_vec   (f_vec),
    .stat      (f_stat)
  );

  qye_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_valid),
    .push_vec (f_vec),
    .pop      (q_pop),
    .pop_vec  (q_vec),
    .stat     (q_stat)
  );

  qye_cordic #(
    .STEPS (STEPS)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_pop),
    .in_vec    (q_vec),
    .out_valid (c_valid),
    .out_z     (c_z)
  );

  qye_map u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c_valid),
    .in_z      (c_z),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `QYE_ASSERT_LAT(a_result_follows, accept, LAT, out_valid)
  `QYE_ASSERT_IMP(a_no_spurious_result, out_valid, $past(accept, LAT))
  `QYE_ASSERT_IMP(a_low_end_code, out_valid && (out_data.yaw_angle == NEG_ANGLE_LIMIT), out_data.yaw_code == '0)

endmodule

### tb/tb.sv
// Self-checking testbench for quaternion_yaw_encoder: fixed-point yaw prediction and scoreboard.
// Depends on qye_pkg for the request and result types and on the encoder RTL.
`timescale 1ns / 1ps
module tb;
  import qye_pkg::*;

  localparam int    STEPS        = 16;
  localparam int    STALL_LIMIT  = 4000;
  localparam int    DRAIN_CYCLES = 10 + STEPS + 20;
  localparam longint ROT_PI      = 64'sd3373259426;
  localparam longint ROT_HALF_PI = 64'sd1686629713;
  localparam longint YAW_LIMIT   = 64'sd25736;

  // Arctangent of 2^-i in Q2.30, rounded to nearest.
  localparam longint ARCTAN_Q30 [24] = '{
    843314857, 497837829, 263043837, 133525159,
    67021687, 33543516, 16775851, 8388437,
    4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048,
    1024, 512, 256, 128
  };

  class yaw_scoreboard;
    yaw_out_t expected_yaw [$];
    int       mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Heading from a quaternion: yaw numerator and denominator, then CORDIC vectoring.
    function yaw_out_t predict_yaw(quat_in_t q);
      longint   w, qx, qy, qz, num, den, vx, vy, ang, t, xs, ys, a, mnum, code;
      int       steps;
      yaw_out_t r;
      w   = $signed(q.quat_w);
      qx  = $signed(q.quat_x);
      qy  = $signed(q.quat_y);
      qz  = $signed(q.quat_z);
      num = 2 * (w * qz + qx * qy);
      den = 64'sd268435456 - 2 * (qy * qy + qz * qz);
      steps = (STEPS > 24) ? 24 : STEPS;
      if (num == 0) begin
        ang = (den < 0) ? ROT_PI : 0;
      end else begin
        vx  = den;
        vy  = num;
        ang = 0;
        // A vector in the left half plane is first turned by a quarter turn.
        if (vx < 0) begin
          t = vx;
          if (vy > 0) begin
            vx  = vy;
            vy  = -t;
            ang = ROT_HALF_PI;
          end else begin
            vx  = -vy;
            vy  = t;
            ang = -ROT_HALF_PI;
          end
        end
        for (int i = 0; i < steps; i++) begin
          xs = vx >>> i;
          ys = vy >>> i;
          if (vy > 0) begin
            vx  = vx + ys;
            vy  = vy - xs;
            ang = ang + ARCTAN_Q30[i];
          end else if (vy < 0) begin
            vx  = vx - ys;
            vy  = vy + xs;
            ang = ang - ARCTAN_Q30[i];
          end
        end
      end
      a = (ang + 65536) >>> 17;
      if (a > YAW_LIMIT) a = YAW_LIMIT;
      if (a < -YAW_LIMIT) a = -YAW_LIMIT;
      mnum = (a * 100000 + 64'sd314159 * 8192) * 65535;
      if (mnum < 0) begin
        code = 0;
      end else begin
        code = mnum / (64'sd628318 * 8192);
        if (code > 65535) code = 65535;
      end
      r.yaw_angle = a[15:0];
      r.yaw_code  = code[15:0];
      return r;
    endfunction

    function void note_request(quat_in_t q);
      expected_yaw.push_back(predict_yaw(q));
    endfunction

    function void check_result(yaw_out_t got);
      yaw_out_t exp_r;
      if (expected_yaw.size() == 0) begin
        $error("unexpected result: yaw_angle %0d, yaw_code %0d",
               $signed(got.yaw_angle), got.yaw_code);
        mismatches++;
        return;
      end
      exp_r = expected_yaw.pop_front();
      if (got.yaw_angle !== exp_r.yaw_angle) begin
        $error("yaw_angle mismatch: expected %0d, actual %0d",
               $signed(exp_r.yaw_angle), $signed(got.yaw_angle));
        mismatches++;
      end
      if (got.yaw_code !== exp_r.yaw_code) begin
        $error("yaw_code mismatch: expected %0d, actual %0d", exp_r.yaw_code, got.yaw_code);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_yaw.size();
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  quat_in_t in_data;
  logic     out_valid;
  yaw_out_t out_data;
  int       stall_cycles;

  yaw_scoreboard sb = new();

  quaternion_yaw_encoder #(.CORDIC_STEPS(STEPS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_request(in_data);
      if (out_valid) sb.check_result(out_data);
    end
  end

  // Ends the run if neither a request nor a result moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic quat_in_t make_quat(input int w, input int x, input int y, input int z);
    quat_in_t q;
    q.quat_w = w[15:0];
    q.quat_x = x[15:0];
    q.quat_y = y[15:0];
    q.quat_z = z[15:0];
    return q;
  endfunction

  // Mostly full-range values, with small vectors and zero-numerator cases mixed in.
  function automatic quat_in_t random_quat();
    quat_in_t q;
    int       pick;
    q.quat_w = 16'($urandom);
    q.quat_x = 16'($urandom);
    q.quat_y = 16'($urandom);
    q.quat_z = 16'($urandom);
    pick = $urandom_range(9);
    if (pick == 0) begin
      q.quat_x = '0;
      q.quat_y = '0;
      if ($urandom_range(1)) q.quat_w = '0;
      else q.quat_z = '0;
    end else if (pick <= 2) begin
      q.quat_w = 16'($signed($urandom_range(32)) - 16);
      q.quat_x = 16'($signed($urandom_range(32)) - 16);
      q.quat_y = 16'($signed($urandom_range(32)) - 16);
      q.quat_z = 16'($signed($urandom_range(32)) - 16);
    end
    return q;
  endfunction

  // Presents one request, idling first at the given percentage, and returns once it is taken.
  task automatic send_quat(input quat_in_t q, input int idle_pct);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start   = 1'b1;
    in_data = q;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    int idle_pct [3];
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    idle_pct = '{0, 69, 28};
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    send_quat(make_quat(0, 0, 0, 0), 0);
    send_quat(make_quat(16384, 0, 0, 0), 0);
    send_quat(make_quat(0, 0, 0, 16384), 0);
    send_quat(make_quat(11585, 0, 0, 11585), 0);
    send_quat(make_quat(11585, 0, 0, -11585), 0);
    send_quat(make_quat(4096, 0, 0, 16000), 0);
    send_quat(make_quat(4096, 0, 0, -16000), 0);
    send_quat(make_quat(1, 0, 0, 16384), 0);
    send_quat(make_quat(1, 0, 0, -16384), 0);
    send_quat(make_quat(-1, 0, 0, 16384), 0);
    // Denominator exactly zero, with zero and non-zero numerator.
    send_quat(make_quat(5, -5, 8192, 8192), 0);
    send_quat(make_quat(100, 0, 8192, 8192), 0);
    send_quat(make_quat(-32768, -32768, -32768, -32768), 0);
    send_quat(make_quat(32767, 32767, 32767, 32767), 0);
    send_quat(make_quat(32767, -32768, 32767, -32768), 0);
    send_quat(make_quat(-32768, 32767, -32768, 32767), 0);
    send_quat(make_quat(32767, 0, 0, -32768), 0);
    send_quat(make_quat(0, 32767, -32768, 0), 0);
    send_quat(make_quat(0, 16384, 16384, 0), 0);
    send_quat(make_quat(16384, 0, 0, 1), 0);
    send_quat(make_quat(16384, 0, 0, -1), 0);
    send_quat(make_quat(-16384, 0, 0, 1), 0);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      for (int n = 0; n < 134; n++) begin
        send_quat(random_quat(), idle_pct[ph]);
        // Hold off mid-phase until the pipeline has emptied.
        if (n == 67) wait_drained();
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
    end
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
